// ===== rtl/fnrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fnrs_pkg;

  // Pixel packing: red 23:16, green 15:8, blue 7:0.
  localparam int PIX_W  = 24;
  localparam int CHAN_W = 8;
  localparam int NCHAN  = 3;

  // Configuration port.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

  // Smallest frame side the filter handles.
  localparam int MIN_SIDE = 3;

  // Default limits of the line stores and row counter.
  localparam int MAX_WIDTH_DEFAULT  = 1024;
  localparam int MAX_HEIGHT_DEFAULT = 1024;

  // Per-channel mean of four pixels, truncated.
  function automatic logic [PIX_W-1:0] mean4(
    input logic [PIX_W-1:0] a,
    input logic [PIX_W-1:0] b,
    input logic [PIX_W-1:0] c,
    input logic [PIX_W-1:0] d
  );
    logic [PIX_W-1:0]    res;
    logic [CHAN_W+1:0]   sum;
    res = '0;
    for (int i = 0; i < NCHAN; i++) begin
      sum = {2'b00, a[i*CHAN_W +: CHAN_W]} + {2'b00, b[i*CHAN_W +: CHAN_W]}
          + {2'b00, c[i*CHAN_W +: CHAN_W]} + {2'b00, d[i*CHAN_W +: CHAN_W]};
      res[i*CHAN_W +: CHAN_W] = sum[CHAN_W+1:2];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fnrs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fnrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/four_neighbor_rgb_smoothing.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-neighbor mean filter for a raster-order stream of 24-bit RGB pixels.
// Input items arrive on in_valid/in_ready with pixel_in; results leave on
// out_valid/out_ready with pixel_out, end_of_frame and last_of_run.
// Each interior pixel becomes the per-channel mean of its left, right,
// upper and lower neighbors; border pixels pass through. The output lags
// one row: the pixel of row y releases the result for row y-1, and on the
// last row each pixel also releases itself, so that row drains at once.
// Row 0 items produce no result.
// An accepted item passes through the working stage and then the result register.
// Throughput is one item per cycle unless the receiver stalls; on the last row
// each item waits until the single output register has taken both of its results.
// Frame size comes from frame_width and frame_height (cfg_we, cfg_index,
// cfg_data), written while the block is idle; out-of-range sizes are clamped.
// Reset clears the row and column counters and restores 640 x 480; the two
// line stores are not cleared and need no clearing pass.
// When the receiver stalls, the result register holds, the working stage
// fills, and in_ready drops until the stall clears; nothing is lost.
module four_neighbor_rgb_smoothing
  import fnrs_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     pixel_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [PIX_W-1:0]     pixel_out,
  output logic                      end_of_frame,
  output logic                      last_of_run
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int SWX = ((CFG_W > XW + 1) ? CFG_W : XW + 1) + 1;
  localparam int SWY = ((CFG_W > YW + 1) ? CFG_W : YW + 1) + 1;

  // Configuration registers keep the written bits.
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size after clamping.
  logic [SWX-1:0] width_eff;
  logic [SWY-1:0] height_eff;

  always_comb begin
    width_eff = SWX'(frame_width);
    if (width_eff < SWX'(MIN_SIDE)) begin
      width_eff = SWX'(MIN_SIDE);
    end else if (width_eff > SWX'(MAX_WIDTH)) begin
      width_eff = SWX'(MAX_WIDTH);
    end
    height_eff = SWY'(frame_height);
    if (height_eff < SWY'(MIN_SIDE)) begin
      height_eff = SWY'(MIN_SIDE);
    end else if (height_eff > SWY'(MAX_HEIGHT)) begin
      height_eff = SWY'(MAX_HEIGHT);
    end
  end

  // Position of the next input item.
  logic [XW-1:0] col_count;
  logic [YW-1:0] row_count;
  logic [SWX-1:0] x_ext;
  logic [SWY-1:0] y_ext;
  logic row_end;
  logic last_row;
  logic interior;

  assign x_ext    = SWX'(col_count);
  assign y_ext    = SWY'(row_count);
  assign row_end  = (x_ext + SWX'(1)) >= width_eff;
  assign last_row = (y_ext + SWY'(1)) >= height_eff;
  assign interior = (col_count != '0) && ((x_ext + SWX'(2)) <= width_eff)
                 && (row_count >= YW'(2)) && ((y_ext + SWY'(1)) <= height_eff);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= last_row ? '0 : YW'(y_ext + SWY'(1));
      end else begin
        col_count <= XW'(x_ext + SWX'(1));
      end
    end
  end

  // Working stage: one item with its flags and line store reads.
  logic             s1_valid;
  logic             s1_phase;
  logic [XW-1:0]    s1_x;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_has_delayed;
  logic             s1_interior;
  logic             s1_last_row;
  logic             s1_row_end;

  // Row y-1 at the current column and one to the left of it.
  logic [PIX_W-1:0] center_reg;
  logic [PIX_W-1:0] left_reg;

  logic [PIX_W-1:0] up_q;
  logic [PIX_W-1:0] right_q;
  logic [XW-1:0]    newer_raddr;
  logic             s1_retire;

  // At a row end the newer store is read at column 0: that is the center
  // of the first pixel of the next row.
  assign newer_raddr = row_end ? '0 : XW'(x_ext + SWX'(1));

  fnrs_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_older_line (
    .clk  (clk),
    .we   (s1_retire),
    .waddr(s1_x),
    .wdata(center_reg),
    .re   (in_fire),
    .raddr(col_count),
    .rdata(up_q)
  );

  fnrs_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_newer_line (
    .clk  (clk),
    .we   (s1_retire),
    .waddr(s1_x),
    .wdata(s1_pix),
    .re   (in_fire),
    .raddr(newer_raddr),
    .rdata(right_q)
  );

  // Result selection for the item in the working stage.
  logic             sel_delayed;
  logic             s1_any;
  logic             s1_final;
  logic             out_space;
  logic             out_load;
  logic [PIX_W-1:0] res_delayed;
  logic [PIX_W-1:0] pixel_out_next;
  logic             end_of_frame_next;
  logic             last_of_run_next;

  assign sel_delayed = s1_has_delayed && !s1_phase;
  assign s1_any      = sel_delayed || s1_last_row;
  assign s1_final    = !(sel_delayed && s1_last_row);
  assign out_space   = !out_valid || out_ready;
  assign out_load    = s1_valid && s1_any && out_space;
  assign s1_retire   = s1_valid && (!s1_any || (out_space && s1_final));
  assign in_ready    = !s1_valid || s1_retire;

  assign res_delayed = s1_interior ? mean4(left_reg, right_q, up_q, s1_pix) : center_reg;

  always_comb begin
    if (sel_delayed) begin
      pixel_out_next    = res_delayed;
      end_of_frame_next = 1'b0;
      last_of_run_next  = !s1_last_row;
    end else begin
      pixel_out_next    = s1_pix;
      end_of_frame_next = s1_row_end;
      last_of_run_next  = 1'b1;
    end
  end

  // Working stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        s1_phase <= 1'b0;
      end else begin
        if (s1_retire) begin
          s1_valid <= 1'b0;
        end
        if (out_load && !s1_final) begin
          s1_phase <= 1'b1;
        end
      end
    end
  end

  // Working stage payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x           <= col_count;
      s1_pix         <= pixel_in;
      s1_has_delayed <= (row_count != '0);
      s1_interior    <= interior;
      s1_last_row    <= last_row;
      s1_row_end     <= row_end;
    end
  end

  // The neighbor window slides by one column as each item retires.
  always_ff @(posedge clk) begin
    if (s1_retire) begin
      left_reg   <= center_reg;
      center_reg <= right_q;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_out    <= pixel_out_next;
      end_of_frame <= end_of_frame_next;
      last_of_run  <= last_of_run_next;
    end
  end

  // Only a last-row item with a delayed result takes a second pass.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_phase) |-> (s1_last_row && s1_has_delayed))
    else $error("second result pending for an item that has only one");

  // A line store write never lands on an entry being read in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && s1_retire) |-> ((col_count != s1_x) && (newer_raddr != s1_x)))
    else $error("line store read collides with write");

  // The last pixel of a frame sends the position back to the frame origin.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && row_end && last_row) |=> ((col_count == '0) && (row_count == '0)))
    else $error("position not restarted after the frame end");

endmodule

`default_nettype wire
